[hdl/stl_pkg.sv]
// ---------------------------------------------------------------------------
// stl_pkg: shared types and constants of the SQL token lexer
// Token kind codes, scan modes, keyword table and the front-to-back word.
// ---------------------------------------------------------------------------
package stl_pkg;

    localparam int KEYWORD_CHARS_DEF = 8;
    localparam int INPUT_SPAN_DEF    = 65536;
    localparam int POS_W             = 16;
    localparam int VAL_W             = 63;
    localparam int KIND_W            = 6;
    localparam int WLEN_W            = 17;
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
    localparam logic [VAL_W-1:0] SAT_LIMIT = VAL_MAX / 10;

    typedef enum logic [KIND_W-1:0] {
        K_SELECT = 6'd0, K_INSERT = 6'd1, K_UPDATE = 6'd2, K_DELETE = 6'd3,
        K_CREATE = 6'd4, K_DROP = 6'd5, K_TABLE = 6'd6, K_FROM = 6'd7,
        K_WHERE = 6'd8, K_INTO = 6'd9, K_VALUES = 6'd10, K_SET = 6'd11,
        K_AND = 6'd12, K_OR = 6'd13, K_NOT = 6'd14, K_NULL = 6'd15,
        K_IS = 6'd16, K_INT = 6'd17, K_FLOAT = 6'd18, K_VARCHAR = 6'd19,
        K_BOOL = 6'd20, K_PRIMARY = 6'd21, K_KEY = 6'd22, K_SHOW = 6'd23,
        K_TABLES = 6'd24, K_DESCRIBE = 6'd25, K_BOOL_LIT = 6'd26,
        K_STRING_LIT = 6'd27, K_FLOAT_LIT = 6'd28, K_INT_LIT = 6'd29,
        K_IDENT = 6'd30, K_COMMA = 6'd31, K_SEMICOLON = 6'd32, K_LPAREN = 6'd33,
        K_RPAREN = 6'd34, K_STAR = 6'd35, K_DOT = 6'd36, K_EQ = 6'd37,
        K_LTE = 6'd38, K_LT = 6'd39, K_GTE = 6'd40, K_GT = 6'd41,
        K_NEQ = 6'd42, K_UNKNOWN = 6'd43, K_EOF = 6'd44
    } kind_t;

    typedef enum logic [3:0] {
        M_IDLE = 4'd0, M_STR = 4'd1, M_ESC = 4'd2, M_NUM = 4'd3,
        M_WORD = 4'd4, M_LT = 4'd5, M_GT = 4'd6, M_BANG = 4'd7
    } mode_t;

    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_EQ = 8'h3D;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  start;
        logic [POS_W-1:0]  length;
        logic [VAL_W-1:0]  value;
        logic              last;
    } token_t;

    // one front-to-back word: a two-token flag, up to two tokens
    typedef struct packed {
        logic   two;
        token_t tok0;
        token_t tok1;
    } pair_t;

    localparam int KW_N = 33;
    localparam int KW_W = 16 * 8;

    typedef struct packed {
        logic [KW_W-1:0]   text;  // left aligned, first char in top byte
        logic [4:0]        len;
        logic [KIND_W-1:0] kind;
        logic              val;
    } kw_t;

    function automatic kw_t kw_entry(input int idx);
        kw_t e;
        e.val = 1'b0;
        unique case (idx)
            0: begin e.text = {"SELECT", 80'h0}; e.len = 5'd6; e.kind = K_SELECT; end
            1: begin e.text = {"INSERT", 80'h0}; e.len = 5'd6; e.kind = K_INSERT; end
            2: begin e.text = {"UPDATE", 80'h0}; e.len = 5'd6; e.kind = K_UPDATE; end
            3: begin e.text = {"DELETE", 80'h0}; e.len = 5'd6; e.kind = K_DELETE; end
            4: begin e.text = {"CREATE", 80'h0}; e.len = 5'd6; e.kind = K_CREATE; end
            5: begin e.text = {"DROP", 96'h0}; e.len = 5'd4; e.kind = K_DROP; end
            6: begin e.text = {"TABLE", 88'h0}; e.len = 5'd5; e.kind = K_TABLE; end
            7: begin e.text = {"FROM", 96'h0}; e.len = 5'd4; e.kind = K_FROM; end
            8: begin e.text = {"WHERE", 88'h0}; e.len = 5'd5; e.kind = K_WHERE; end
            9: begin e.text = {"INTO", 96'h0}; e.len = 5'd4; e.kind = K_INTO; end
            10: begin e.text = {"VALUES", 80'h0}; e.len = 5'd6; e.kind = K_VALUES; end
            11: begin e.text = {"SET", 104'h0}; e.len = 5'd3; e.kind = K_SET; end
            12: begin e.text = {"AND", 104'h0}; e.len = 5'd3; e.kind = K_AND; end
            13: begin e.text = {"OR", 112'h0}; e.len = 5'd2; e.kind = K_OR; end
            14: begin e.text = {"NOT", 104'h0}; e.len = 5'd3; e.kind = K_NOT; end
            15: begin e.text = {"NULL", 96'h0}; e.len = 5'd4; e.kind = K_NULL; end
            16: begin e.text = {"IS", 112'h0}; e.len = 5'd2; e.kind = K_IS; end
            17: begin e.text = {"INT", 104'h0}; e.len = 5'd3; e.kind = K_INT; end
            18: begin e.text = {"INTEGER", 72'h0}; e.len = 5'd7; e.kind = K_INT; end
            19: begin e.text = {"FLOAT", 88'h0}; e.len = 5'd5; e.kind = K_FLOAT; end
            20: begin e.text = {"DOUBLE", 80'h0}; e.len = 5'd6; e.kind = K_FLOAT; end
            21: begin e.text = {"VARCHAR", 72'h0}; e.len = 5'd7; e.kind = K_VARCHAR; end
            22: begin e.text = {"TEXT", 96'h0}; e.len = 5'd4; e.kind = K_VARCHAR; end
            23: begin e.text = {"BOOL", 96'h0}; e.len = 5'd4; e.kind = K_BOOL; end
            24: begin e.text = {"BOOLEAN", 72'h0}; e.len = 5'd7; e.kind = K_BOOL; end
            25: begin e.text = {"PRIMARY", 72'h0}; e.len = 5'd7; e.kind = K_PRIMARY; end
            26: begin e.text = {"KEY", 104'h0}; e.len = 5'd3; e.kind = K_KEY; end
            27: begin e.text = {"SHOW", 96'h0}; e.len = 5'd4; e.kind = K_SHOW; end
            28: begin e.text = {"TABLES", 80'h0}; e.len = 5'd6; e.kind = K_TABLES; end
            29: begin e.text = {"DESCRIBE", 64'h0}; e.len = 5'd8; e.kind = K_DESCRIBE; end
            30: begin e.text = {"DESC", 96'h0}; e.len = 5'd4; e.kind = K_DESCRIBE; end
            31: begin e.text = {"TRUE", 96'h0}; e.len = 5'd4; e.kind = K_BOOL_LIT;
                e.val = 1'b1; end
            default: begin e.text = {"FALSE", 88'h0}; e.len = 5'd5; e.kind = K_BOOL_LIT; end
        endcase
        return e;
    endfunction

endpackage

[hdl/stl_if.sv]
// ---------------------------------------------------------------------------
// stl_in_if / stl_out_if: valid/ready channels of the lexer
// Input bytes and output tokens.
// ---------------------------------------------------------------------------
interface stl_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] text_byte;
    modport source (output valid, output action, output text_byte, input ready);
    modport sink (input valid, input action, input text_byte, output ready);
endinterface

interface stl_out_if;
    logic                       valid;
    logic                       ready;
    logic [stl_pkg::KIND_W-1:0] token_kind;
    logic [stl_pkg::POS_W-1:0]  token_start;
    logic [stl_pkg::POS_W-1:0]  token_length;
    logic [stl_pkg::VAL_W-1:0]  int_value;
    logic                       last_of_run;
    modport source (output valid, output token_kind, output token_start,
                    output token_length, output int_value, output last_of_run,
                    input ready);
    modport sink (input valid, input token_kind, input token_start,
                  input token_length, input int_value, input last_of_run,
                  output ready);
endinterface

[hdl/sql_token_lexer_unit.sv]
// ---------------------------------------------------------------------------
// sql_token_lexer_unit: streaming SQL tokenizer
// Byte scanner in front, token queue behind.
//
//   channel | dir | word
//   in      | in  | action, text_byte
//   out     | out | token_kind, token_start, token_length, int_value, last_of_run
//
// One byte is taken each cycle while the two-entry token queue has room.
// A byte that yields two tokens holds its queue slot until both are sent.
// Tokens appear in the cycle after their byte at the earliest.
// Reset clears scan state and queue; no clearing pass.
// ---------------------------------------------------------------------------
module sql_token_lexer_unit #(
    parameter int KEYWORD_CHARS = stl_pkg::KEYWORD_CHARS_DEF,
    parameter int INPUT_SPAN    = stl_pkg::INPUT_SPAN_DEF
) (
    input logic       clk,
    input logic       rst_n,
    stl_in_if.sink    in,
    stl_out_if.source out
);
    logic           q_push, q_full;
    stl_pkg::pair_t q_data;

    stl_front #(.KEYWORD_CHARS(KEYWORD_CHARS), .INPUT_SPAN(INPUT_SPAN)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in.valid), .in_action(in.action), .in_byte(in.text_byte),
        .in_ready(in.ready),
        .q_push(q_push), .q_data(q_data), .q_full(q_full)
    );

    stl_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_push(q_push), .q_data(q_data), .q_full(q_full), .out(out)
    );
endmodule

[hdl/stl_front.sv]
// ---------------------------------------------------------------------------
// stl_front: byte scanner
// Keeps the scan mode, classifies each byte and forms up to two tokens.
// ---------------------------------------------------------------------------
module stl_front #(
    parameter int KEYWORD_CHARS = stl_pkg::KEYWORD_CHARS_DEF,
    parameter int INPUT_SPAN    = stl_pkg::INPUT_SPAN_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_action,
    input  logic [7:0]     in_byte,
    output logic           in_ready,
    output logic           q_push,
    output stl_pkg::pair_t q_data,
    input  logic           q_full
);
    localparam int SPAN_W = $clog2(INPUT_SPAN);
    localparam int WIDX_W = $clog2(KEYWORD_CHARS);

    stl_pkg::mode_t               mode_reg, mode_next;
    logic [KEYWORD_CHARS*8-1:0]   wbuf_reg, wbuf_next;
    logic [stl_pkg::WLEN_W-1:0]   wlen_reg, wlen_next;
    logic [stl_pkg::VAL_W-1:0]    acc_reg, acc_next;
    logic                         dot_reg, dot_next;
    logic [SPAN_W-1:0]            origin_reg, origin_next;
    logic [SPAN_W-1:0]            pos_reg, pos_next;

    logic                         take;
    logic                         is_dig, is_alp, is_spc, is_wch;
    logic [SPAN_W-1:0]            span, span1;
    logic [7:0]                   up;
    logic [stl_pkg::VAL_W-1:0]    dval, acc_dig;
    stl_pkg::token_t              ntok [2];
    logic [1:0]                   cnt;
    stl_pkg::token_t              wtok;
    logic                         idle_go;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    assign is_dig = in_byte >= "0" && in_byte <= "9";
    assign is_alp = (in_byte >= "A" && in_byte <= "Z") || (in_byte >= "a" && in_byte <= "z");
    assign is_spc = in_byte == " " || (in_byte >= 8'd9 && in_byte <= 8'd13);
    assign is_wch = is_alp || is_dig || in_byte == stl_pkg::CH_UNDER;
    assign up     = (in_byte >= "a" && in_byte <= "z") ? in_byte - 8'd32 : in_byte;
    // distance modulo the span, which need not be a power of two
    assign span   = (pos_reg >= origin_reg) ? pos_reg - origin_reg
                                            : pos_reg + SPAN_W'(INPUT_SPAN) - origin_reg;
    assign span1  = span + SPAN_W'(1);
    assign dval   = stl_pkg::VAL_W'(in_byte - "0");

    function automatic stl_pkg::token_t mk(input stl_pkg::kind_t k,
                                           input logic [SPAN_W-1:0] s,
                                           input logic [SPAN_W-1:0] l,
                                           input logic [stl_pkg::VAL_W-1:0] v);
        stl_pkg::token_t t;
        t.kind   = k;
        t.start  = stl_pkg::POS_W'(s);
        t.length = stl_pkg::POS_W'(l);
        t.value  = v;
        t.last   = 1'b0;
        return t;
    endfunction

    // saturating acc*10+d; acc*10 fits once acc <= limit
    always_comb
    begin
        logic [stl_pkg::VAL_W+3:0] prod;
        prod = {4'd0, acc_reg} * 67'd10 + {4'd0, dval};
        if (acc_reg > stl_pkg::SAT_LIMIT || prod > {4'd0, stl_pkg::VAL_MAX})
            acc_dig = stl_pkg::VAL_MAX;
        else
            acc_dig = prod[stl_pkg::VAL_W-1:0];
    end

    // keyword compare, all entries in parallel
    always_comb
    begin
        logic              hit;
        logic              match;
        stl_pkg::kw_t      e;
        hit  = 1'b0;
        wtok = mk(stl_pkg::K_IDENT, origin_reg, span, '0);
        for (int i = 0; i < stl_pkg::KW_N; i++)
        begin
            e = stl_pkg::kw_entry(i);
            // bytes past the word length are stale
            match = wlen_reg == stl_pkg::WLEN_W'(e.len);
            for (int j = 0; j < KEYWORD_CHARS; j++)
                if (j < int'(e.len) &&
                    e.text[stl_pkg::KW_W-1-j*8 -: 8] != wbuf_reg[j*8 +: 8])
                    match = 1'b0;
            if (!hit && match)
            begin
                hit  = 1'b1;
                wtok = mk(stl_pkg::kind_t'(e.kind), origin_reg, span,
                          stl_pkg::VAL_W'(e.val));
            end
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        wbuf_next   = wbuf_reg;
        wlen_next   = wlen_reg;
        acc_next    = acc_reg;
        dot_next    = dot_reg;
        origin_next = origin_reg;
        pos_next    = pos_reg;
        cnt         = 2'd0;
        ntok[0]     = mk(stl_pkg::K_EOF, pos_reg, '0, '0);
        ntok[1]     = ntok[0];
        idle_go     = 1'b0;
        if (in_action)
        begin
            priority case (mode_reg)
                stl_pkg::M_STR, stl_pkg::M_ESC:
                    begin ntok[0] = mk(stl_pkg::K_STRING_LIT, origin_reg, span, '0); cnt = 2'd1; end
                stl_pkg::M_NUM:
                    begin
                        ntok[0] = mk(dot_reg ? stl_pkg::K_FLOAT_LIT : stl_pkg::K_INT_LIT,
                                     origin_reg, span, dot_reg ? '0 : acc_reg);
                        cnt = 2'd1;
                    end
                stl_pkg::M_WORD: begin ntok[0] = wtok; cnt = 2'd1; end
                stl_pkg::M_LT:
                    begin ntok[0] = mk(stl_pkg::K_LT, origin_reg, SPAN_W'(1), '0); cnt = 2'd1; end
                stl_pkg::M_GT:
                    begin ntok[0] = mk(stl_pkg::K_GT, origin_reg, SPAN_W'(1), '0); cnt = 2'd1; end
                default: ;
            endcase
            ntok[cnt[0]] = mk(stl_pkg::K_EOF, pos_reg, '0, '0);
            cnt = cnt + 2'd1;
            mode_next = stl_pkg::M_IDLE;
            wlen_next = '0; acc_next = '0; dot_next = 1'b0;
            origin_next = '0; pos_next = '0;
        end
        else
        begin
            priority case (mode_reg)
                stl_pkg::M_STR:
                    if (in_byte == stl_pkg::CH_QUOTE)
                    begin
                        ntok[0] = mk(stl_pkg::K_STRING_LIT, origin_reg, span1, '0);
                        cnt = 2'd1; mode_next = stl_pkg::M_IDLE;
                    end
                    else if (in_byte == stl_pkg::CH_BSLASH)
                        mode_next = stl_pkg::M_ESC;
                stl_pkg::M_ESC: mode_next = stl_pkg::M_STR;
                stl_pkg::M_NUM:
                    if (is_dig) begin if (!dot_reg) acc_next = acc_dig; end
                    else if (in_byte == stl_pkg::CH_DOT) dot_next = 1'b1;
                    else
                    begin
                        ntok[0] = mk(dot_reg ? stl_pkg::K_FLOAT_LIT : stl_pkg::K_INT_LIT,
                                     origin_reg, span, dot_reg ? '0 : acc_reg);
                        cnt = 2'd1; idle_go = 1'b1;
                    end
                stl_pkg::M_WORD:
                    if (is_wch)
                    begin
                        if (wlen_reg < stl_pkg::WLEN_W'(KEYWORD_CHARS))
                            wbuf_next[WIDX_W'(wlen_reg[WIDX_W-1:0])*8 +: 8] = up;
                        if (wlen_reg != '1) wlen_next = wlen_reg + 1'b1;
                    end
                    else begin ntok[0] = wtok; cnt = 2'd1; idle_go = 1'b1; end
                stl_pkg::M_LT, stl_pkg::M_GT, stl_pkg::M_BANG:
                    if (in_byte == stl_pkg::CH_EQ)
                    begin
                        ntok[0] = mk(mode_reg == stl_pkg::M_LT ? stl_pkg::K_LTE :
                                     mode_reg == stl_pkg::M_GT ? stl_pkg::K_GTE :
                                     stl_pkg::K_NEQ, origin_reg, span1, '0);
                        cnt = 2'd1; mode_next = stl_pkg::M_IDLE;
                    end
                    else
                    begin
                        if (mode_reg != stl_pkg::M_BANG)
                        begin
                            ntok[0] = mk(mode_reg == stl_pkg::M_LT ? stl_pkg::K_LT
                                         : stl_pkg::K_GT, origin_reg, SPAN_W'(1), '0);
                            cnt = 2'd1;
                        end
                        idle_go = 1'b1;
                    end
                default: idle_go = 1'b1;
            endcase
            if (idle_go)
            begin
                mode_next = stl_pkg::M_IDLE;
                if (!is_spc)
                begin
                    origin_next = pos_reg;
                    if (in_byte == stl_pkg::CH_QUOTE) mode_next = stl_pkg::M_STR;
                    else if (is_dig)
                    begin
                        acc_next = dval; dot_next = 1'b0; mode_next = stl_pkg::M_NUM;
                    end
                    else if (is_alp || in_byte == stl_pkg::CH_UNDER)
                    begin
                        wbuf_next[7:0] = up; wlen_next = stl_pkg::WLEN_W'(1);
                        mode_next = stl_pkg::M_WORD;
                    end
                    else if (in_byte == "<") mode_next = stl_pkg::M_LT;
                    else if (in_byte == ">") mode_next = stl_pkg::M_GT;
                    else if (in_byte == "!") mode_next = stl_pkg::M_BANG;
                    else
                    begin
                        ntok[cnt[0]] = mk(in_byte == "," ? stl_pkg::K_COMMA :
                                          in_byte == ";" ? stl_pkg::K_SEMICOLON :
                                          in_byte == "(" ? stl_pkg::K_LPAREN :
                                          in_byte == ")" ? stl_pkg::K_RPAREN :
                                          in_byte == "*" ? stl_pkg::K_STAR :
                                          in_byte == "." ? stl_pkg::K_DOT :
                                          in_byte == "=" ? stl_pkg::K_EQ :
                                          stl_pkg::K_UNKNOWN, pos_reg, SPAN_W'(1), '0);
                        cnt = cnt + 2'd1;
                    end
                end
            end
            pos_next = (pos_reg == SPAN_W'(INPUT_SPAN - 1)) ? '0 : pos_reg + 1'b1;
        end
    end

    always_comb
    begin
        q_data.two  = cnt == 2'd2;
        q_data.tok0 = ntok[0];
        q_data.tok1 = ntok[1];
        if (cnt == 2'd2) q_data.tok1.last = 1'b1;
        else q_data.tok0.last = 1'b1;
    end
    assign q_push = take && cnt != 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= stl_pkg::M_IDLE;
            wlen_reg   <= '0;
            acc_reg    <= '0;
            dot_reg    <= 1'b0;
            origin_reg <= '0;
            pos_reg    <= '0;
        end
        else if (take)
        begin
            mode_reg   <= mode_next;
            wlen_reg   <= wlen_next;
            acc_reg    <= acc_next;
            dot_reg    <= dot_next;
            origin_reg <= origin_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            wbuf_reg <= wbuf_next;
    end
endmodule

[hdl/stl_back.sv]
// ---------------------------------------------------------------------------
// stl_back: token queue and output sequencer
// Two-entry queue of token pairs; sends one token per cycle while out.ready is high.
// ---------------------------------------------------------------------------
module stl_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_push,
    input  stl_pkg::pair_t q_data,
    output logic           q_full,
    stl_out_if.source      out
);
    stl_pkg::pair_t  mem_reg [2];
    logic            wp_reg, rp_reg, half_reg;
    logic [1:0]      fill_reg;
    logic            pop_tok, pop_pair;
    stl_pkg::token_t cur;

    assign q_full = fill_reg == 2'd2;
    assign cur    = half_reg ? mem_reg[rp_reg].tok1 : mem_reg[rp_reg].tok0;

    assign out.valid        = fill_reg != 2'd0;
    assign out.token_kind   = cur.kind;
    assign out.token_start  = cur.start;
    assign out.token_length = cur.length;
    assign out.int_value    = cur.value;
    assign out.last_of_run  = cur.last;

    assign pop_tok  = out.valid && out.ready;
    assign pop_pair = pop_tok && (half_reg || !mem_reg[rp_reg].two);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; half_reg <= 1'b0; fill_reg <= 2'd0;
        end
        else
        begin
            if (q_push) wp_reg <= ~wp_reg;
            if (pop_pair) begin rp_reg <= ~rp_reg; half_reg <= 1'b0; end
            else if (pop_tok) half_reg <= 1'b1;
            fill_reg <= fill_reg + {1'b0, q_push} - {1'b0, pop_pair};
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push) mem_reg[wp_reg] <= q_data;
    end
endmodule

[hdl/stl_checker.sv]
// ---------------------------------------------------------------------------
// stl_checker: port-level checks of the lexer
// ---------------------------------------------------------------------------
module stl_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [stl_pkg::KIND_W-1:0] token_kind,
    input logic [stl_pkg::POS_W-1:0]  token_length,
    input logic                       last_of_run
);
    a_eof_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == stl_pkg::K_EOF |-> token_length == '0)
        else $error("EOF word with nonzero length");
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == stl_pkg::K_EOF |-> last_of_run)
        else $error("EOF word not last");
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_kind <= stl_pkg::K_EOF)
        else $error("bad kind");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind))
        else $error("output word dropped under stall");
    a_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> !$isunknown(in_ready))
        else $error("input ready unknown");
endmodule

bind sql_token_lexer_unit stl_checker u_stl_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready),
    .token_kind(out.token_kind), .token_length(out.token_length),
    .last_of_run(out.last_of_run)
);
